// ===== rtl/pidc_pkg.sv =====
// Package: shared constants, register map and configuration bundle for the PID unit.
package pidc_pkg;

   // Fixed field widths
   localparam int GAIN_W   = 24;
   localparam int LIMIT_W  = 15;
   localparam int DBAND_W  = 12;
   localparam int SETPT_W  = 12;
   localparam int SUM_W    = 16;
   localparam int DRIVE_W  = 16;
   localparam int CSR_AW   = 5;
   localparam int CSR_DW   = 32;
   localparam int REG_IDX_W = 3;

   // Register indexes (byte address = 4 * index)
   localparam logic [REG_IDX_W-1:0] REG_SETPOINT       = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_GAIN_P         = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_GAIN_I         = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_GAIN_D         = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_OUTPUT_LIMIT   = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_DEADBAND       = 3'd6;

   // Reset values
   localparam logic [SETPT_W-1:0] SETPOINT_RST       = 12'd1000;
   localparam logic [GAIN_W-1:0]  GAIN_P_RST         = 24'd655;
   localparam logic [GAIN_W-1:0]  GAIN_I_RST         = 24'd6554;
   localparam logic [GAIN_W-1:0]  GAIN_D_RST         = 24'd327680;
   localparam logic [LIMIT_W-1:0] INTEGRAL_LIMIT_RST = 15'd100;
   localparam logic [LIMIT_W-1:0] OUTPUT_LIMIT_RST   = 15'd100;
   localparam logic [DBAND_W-1:0] DEADBAND_RST       = 12'd0;

   typedef struct packed {
      logic [GAIN_W-1:0]  gain_p;
      logic [GAIN_W-1:0]  gain_i;
      logic [GAIN_W-1:0]  gain_d;
      logic [LIMIT_W-1:0] integral_limit;
      logic [LIMIT_W-1:0] output_limit;
      logic [DBAND_W-1:0] deadband;
   } cfg_type;

endpackage

// ===== rtl/pidc_req_if.sv =====
// Interface: sample channel (valid/ready plus measured reading).
interface pidc_req_if #(
   parameter int SAMPLE_BITS = 12
) ();
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] measured;

   modport source (output valid, output measured, input ready);
   modport sink   (input valid, input measured, output ready);
endinterface

// ===== rtl/pidc_rsp_if.sv =====
// Interface: result channel (valid/ready plus drive and deadband flag).
interface pidc_rsp_if ();
   logic               valid;
   logic               ready;
   logic signed [15:0] drive;
   logic               in_deadband;

   modport source (output valid, output drive, output in_deadband, input ready);
   modport sink   (input valid, input drive, input in_deadband, output ready);
endinterface

// ===== rtl/pidc_csr.sv =====
// Module: APB-style configuration register file.
module pidc_csr
   import pidc_pkg::*;
#(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CSR_AW-1:0]      paddr,
   input  logic [CSR_DW-1:0]      pwdata,
   output logic [CSR_DW-1:0]      prdata,
   output logic                   pready,
   output logic [SAMPLE_BITS-1:0] setpoint,
   output cfg_type                cfg
);
   // setpoint keeps the low 12 bits, further masked to the sample width
   localparam int SPW = (SAMPLE_BITS < SETPT_W) ? SAMPLE_BITS : SETPT_W;

   logic [SPW-1:0]       setpoint_ff;
   cfg_type              cfg_ff;
   logic [REG_IDX_W-1:0] idx;
   logic                 wr_en;

   assign idx    = paddr[CSR_AW-1:2];
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff           <= SPW'(SETPOINT_RST);
         cfg_ff.gain_p         <= GAIN_P_RST;
         cfg_ff.gain_i         <= GAIN_I_RST;
         cfg_ff.gain_d         <= GAIN_D_RST;
         cfg_ff.integral_limit <= INTEGRAL_LIMIT_RST;
         cfg_ff.output_limit   <= OUTPUT_LIMIT_RST;
         cfg_ff.deadband       <= DEADBAND_RST;
      end else if (wr_en) begin
         unique case (idx)
            REG_SETPOINT:       setpoint_ff           <= pwdata[SPW-1:0];
            REG_GAIN_P:         cfg_ff.gain_p         <= pwdata[GAIN_W-1:0];
            REG_GAIN_I:         cfg_ff.gain_i         <= pwdata[GAIN_W-1:0];
            REG_GAIN_D:         cfg_ff.gain_d         <= pwdata[GAIN_W-1:0];
            REG_INTEGRAL_LIMIT: cfg_ff.integral_limit <= pwdata[LIMIT_W-1:0];
            REG_OUTPUT_LIMIT:   cfg_ff.output_limit   <= pwdata[LIMIT_W-1:0];
            REG_DEADBAND:       cfg_ff.deadband       <= pwdata[DBAND_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_SETPOINT:       prdata = CSR_DW'(setpoint_ff);
         REG_GAIN_P:         prdata = CSR_DW'(cfg_ff.gain_p);
         REG_GAIN_I:         prdata = CSR_DW'(cfg_ff.gain_i);
         REG_GAIN_D:         prdata = CSR_DW'(cfg_ff.gain_d);
         REG_INTEGRAL_LIMIT: prdata = CSR_DW'(cfg_ff.integral_limit);
         REG_OUTPUT_LIMIT:   prdata = CSR_DW'(cfg_ff.output_limit);
         REG_DEADBAND:       prdata = CSR_DW'(cfg_ff.deadband);
         default:            prdata = '0;
      endcase
   end

   assign setpoint = SAMPLE_BITS'(setpoint_ff);
   assign cfg      = cfg_ff;
endmodule

// ===== rtl/pidc_error.sv =====
// Module: sample register, error/deadband/integral/derivative stage and loop state.
module pidc_error
   import pidc_pkg::*;
#(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [SAMPLE_BITS-1:0]        in_measured,
   input  logic [SAMPLE_BITS-1:0]        setpoint,
   input  cfg_type                       cfg,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [SAMPLE_BITS:0]   out_err,
   output logic signed [SUM_W-1:0]       out_sum,
   output logic signed [SAMPLE_BITS+1:0] out_deriv,
   output logic                          out_dband
);
   localparam int EW  = SAMPLE_BITS + 1;
   localparam int DW  = SAMPLE_BITS + 2;
   localparam int SW  = ((SUM_W > EW) ? SUM_W : EW) + 1;
   localparam int DBW = (SAMPLE_BITS > DBAND_W) ? SAMPLE_BITS : DBAND_W;

   logic                   smp_vld_ff, smp_vld_in;
   logic [SAMPLE_BITS-1:0] meas_ff;
   logic                   stg_vld_ff, stg_vld_in;
   logic signed [EW-1:0]   err_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic signed [DW-1:0]   deriv_ff;
   logic                   dband_ff;

   // loop state
   logic signed [SUM_W-1:0] error_sum_ff;
   logic signed [EW-1:0]    prev_err_ff;

   logic                    take, move;
   logic signed [EW-1:0]    err, neg_err;
   logic [SAMPLE_BITS-1:0]  mag;
   logic                    dband;
   logic signed [SW-1:0]    sum_raw, lim_pos, lim_neg;
   logic signed [SUM_W-1:0] sum_cl;
   logic signed [DW-1:0]    deriv;

   assign in_ready = !smp_vld_ff || !stg_vld_ff || out_ready;
   assign take     = in_valid && in_ready;
   assign move     = smp_vld_ff && (!stg_vld_ff || out_ready);

   always_comb begin
      err     = $signed({1'b0, meas_ff}) - $signed({1'b0, setpoint});
      neg_err = -err;
      mag     = err[EW-1] ? neg_err[SAMPLE_BITS-1:0] : err[SAMPLE_BITS-1:0];
      dband   = DBW'(mag) <= DBW'(cfg.deadband);

      sum_raw = SW'(error_sum_ff) + SW'(err);
      lim_pos = $signed(SW'(cfg.integral_limit));
      lim_neg = -lim_pos;
      if (sum_raw > lim_pos)      sum_cl = lim_pos[SUM_W-1:0];
      else if (sum_raw < lim_neg) sum_cl = lim_neg[SUM_W-1:0];
      else                        sum_cl = sum_raw[SUM_W-1:0];

      deriv = DW'(err) - DW'(prev_err_ff);

      smp_vld_in = take ? 1'b1 : (move ? 1'b0 : smp_vld_ff);
      stg_vld_in = move ? 1'b1 : (out_ready ? 1'b0 : stg_vld_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smp_vld_ff   <= 1'b0;
         stg_vld_ff   <= 1'b0;
         error_sum_ff <= '0;
         prev_err_ff  <= '0;
      end else begin
         smp_vld_ff <= smp_vld_in;
         stg_vld_ff <= stg_vld_in;
         if (move && !dband) begin
            error_sum_ff <= sum_cl;
            prev_err_ff  <= err;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         meas_ff <= in_measured;
      end
      if (move) begin
         err_ff   <= err;
         sum_ff   <= sum_cl;
         deriv_ff <= deriv;
         dband_ff <= dband;
      end
   end

   assign out_valid = stg_vld_ff;
   assign out_err   = err_ff;
   assign out_sum   = sum_ff;
   assign out_deriv = deriv_ff;
   assign out_dband = dband_ff;
endmodule

// ===== rtl/pidc_mult.sv =====
// Module: gain multiply stage, three registered signed products.
module pidc_mult
   import pidc_pkg::*;
#(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  logic signed [SAMPLE_BITS:0]          in_err,
   input  logic signed [SUM_W-1:0]              in_sum,
   input  logic signed [SAMPLE_BITS+1:0]        in_deriv,
   input  logic                                 in_dband,
   input  cfg_type                              cfg,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic signed [GAIN_W+SAMPLE_BITS+1:0] out_prod_p,
   output logic signed [GAIN_W+SUM_W:0]         out_prod_i,
   output logic signed [GAIN_W+SAMPLE_BITS+2:0] out_prod_d,
   output logic                                 out_dband
);
   localparam int PPW = GAIN_W + 1 + SAMPLE_BITS + 1;
   localparam int PIW = GAIN_W + 1 + SUM_W;
   localparam int PDW = GAIN_W + 1 + SAMPLE_BITS + 2;

   logic                  vld_ff, vld_in, move;
   logic signed [GAIN_W:0] gp, gi, gd;
   logic signed [PPW-1:0] prod_p_ff, prod_p_in;
   logic signed [PIW-1:0] prod_i_ff, prod_i_in;
   logic signed [PDW-1:0] prod_d_ff, prod_d_in;
   logic                  dband_ff;

   assign in_ready = !vld_ff || out_ready;
   assign move     = in_valid && in_ready;

   always_comb begin
      gp        = $signed({1'b0, cfg.gain_p});
      gi        = $signed({1'b0, cfg.gain_i});
      gd        = $signed({1'b0, cfg.gain_d});
      prod_p_in = gp * in_err;
      prod_i_in = gi * in_sum;
      prod_d_in = gd * in_deriv;
      vld_in    = move ? 1'b1 : (out_ready ? 1'b0 : vld_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         prod_p_ff <= prod_p_in;
         prod_i_ff <= prod_i_in;
         prod_d_ff <= prod_d_in;
         dband_ff  <= in_dband;
      end
   end

   assign out_valid  = vld_ff;
   assign out_prod_p = prod_p_ff;
   assign out_prod_i = prod_i_ff;
   assign out_prod_d = prod_d_ff;
   assign out_dband  = dband_ff;
endmodule

// ===== rtl/pidc_out.sv =====
// Module: product sum, output clamp, truncation toward zero and result register.
module pidc_out
   import pidc_pkg::*;
#(
   parameter int SAMPLE_BITS    = 12,
   parameter int GAIN_FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  logic signed [GAIN_W+SAMPLE_BITS+1:0] in_prod_p,
   input  logic signed [GAIN_W+SUM_W:0]         in_prod_i,
   input  logic signed [GAIN_W+SAMPLE_BITS+2:0] in_prod_d,
   input  logic                                 in_dband,
   input  cfg_type                              cfg,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic signed [DRIVE_W-1:0]            out_drive,
   output logic                                 out_dband
);
   localparam int PDW = GAIN_W + SAMPLE_BITS + 3;
   localparam int PIW = GAIN_W + SUM_W + 1;
   localparam int PW  = (PDW > PIW) ? PDW : PIW;
   localparam int TW  = PW + 2;

   logic                      vld_ff, vld_in, move;
   logic signed [TW-1:0]      total, lim_pos, lim_neg, clamped, mag;
   logic [TW-1:0]             whole;
   logic signed [DRIVE_W-1:0] drive;
   logic signed [DRIVE_W-1:0] drive_ff;
   logic                      dband_ff;

   assign in_ready = !vld_ff || out_ready;
   assign move     = in_valid && in_ready;

   always_comb begin
      total   = TW'(in_prod_p) + TW'(in_prod_i) + TW'(in_prod_d);
      lim_pos = $signed(TW'({cfg.output_limit, {GAIN_FRAC_BITS{1'b0}}}));
      lim_neg = -lim_pos;
      if (total > lim_pos)      clamped = lim_pos;
      else if (total < lim_neg) clamped = lim_neg;
      else                      clamped = total;
      // drop fraction bits of the magnitude, then restore the sign
      mag   = clamped[TW-1] ? -clamped : clamped;
      whole = $unsigned(mag) >> GAIN_FRAC_BITS;
      if (in_dband)             drive = '0;
      else if (clamped[TW-1])   drive = -$signed(whole[DRIVE_W-1:0]);
      else                      drive = $signed(whole[DRIVE_W-1:0]);
      vld_in = move ? 1'b1 : (out_ready ? 1'b0 : vld_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         drive_ff <= drive;
         dband_ff <= in_dband;
      end
   end

   assign out_valid = vld_ff;
   assign out_drive = drive_ff;
   assign out_dband = dband_ff;
endmodule

// ===== rtl/pid_with_deadband_and_clamps_unit.sv =====
// Top level: PID regulator with deadband, integral clamp and output clamp.
// The unit takes one sensor sample per transaction on req_chan and returns one
// drive value per sample on rsp_chan, in order. Sustained rate is one transaction
// per clock while rsp_chan is not stalled. There are four register stages; in order
// from req_chan toward rsp_chan they are the sample register, the
// error stage (error, deadband test, clamped integral sum, derivative, loop state
// update), the gain multiply stage (three signed products) and the result stage
// (product sum, clamp to +/- output_limit, truncate toward zero). Any stage
// holds while the one after it is full and stalled, so rsp backpressure reaches
// req_chan.ready only when all four stages are occupied. A sample whose error
// magnitude is at or below deadband gives drive 0 with in_deadband set and
// leaves the integral sum and stored error untouched. Configuration goes over
// the csr_ APB port (register i at byte address 4*i, pready always high) and is
// meant to change only while no transaction is in flight.
module pid_with_deadband_and_clamps_unit
   import pidc_pkg::*;
#(
   parameter int SAMPLE_BITS    = 12,
   parameter int GAIN_FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   pidc_req_if.sink          req_chan,
   pidc_rsp_if.source        rsp_chan,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);
   logic [SAMPLE_BITS-1:0] setpoint;
   cfg_type                cfg;

   // error stage -> multiply stage
   logic                          e_valid, e_ready;
   logic signed [SAMPLE_BITS:0]   e_err;
   logic signed [SUM_W-1:0]       e_sum;
   logic signed [SAMPLE_BITS+1:0] e_deriv;
   logic                          e_dband;

   // multiply stage -> result stage
   logic                                 m_valid, m_ready;
   logic signed [GAIN_W+SAMPLE_BITS+1:0] m_prod_p;
   logic signed [GAIN_W+SUM_W:0]         m_prod_i;
   logic signed [GAIN_W+SAMPLE_BITS+2:0] m_prod_d;
   logic                                 m_dband;

   pidc_csr #(.SAMPLE_BITS(SAMPLE_BITS)) u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (csr_psel),
      .penable  (csr_penable),
      .pwrite   (csr_pwrite),
      .paddr    (csr_paddr),
      .pwdata   (csr_pwdata),
      .prdata   (csr_prdata),
      .pready   (csr_pready),
      .setpoint (setpoint),
      .cfg      (cfg)
   );

   pidc_error #(.SAMPLE_BITS(SAMPLE_BITS)) u_error (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_chan.valid),
      .in_ready    (req_chan.ready),
      .in_measured (req_chan.measured),
      .setpoint    (setpoint),
      .cfg         (cfg),
      .out_valid   (e_valid),
      .out_ready   (e_ready),
      .out_err     (e_err),
      .out_sum     (e_sum),
      .out_deriv   (e_deriv),
      .out_dband   (e_dband)
   );

   pidc_mult #(.SAMPLE_BITS(SAMPLE_BITS)) u_mult (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (e_valid),
      .in_ready   (e_ready),
      .in_err     (e_err),
      .in_sum     (e_sum),
      .in_deriv   (e_deriv),
      .in_dband   (e_dband),
      .cfg        (cfg),
      .out_valid  (m_valid),
      .out_ready  (m_ready),
      .out_prod_p (m_prod_p),
      .out_prod_i (m_prod_i),
      .out_prod_d (m_prod_d),
      .out_dband  (m_dband)
   );

   pidc_out #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (m_valid),
      .in_ready  (m_ready),
      .in_prod_p (m_prod_p),
      .in_prod_i (m_prod_i),
      .in_prod_d (m_prod_d),
      .in_dband  (m_dband),
      .cfg       (cfg),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_drive (rsp_chan.drive),
      .out_dband (rsp_chan.in_deadband)
   );
endmodule

// ===== rtl/pidc_checker.sv =====
// Checker: port-level assertions for the PID unit, bound to the top level.
module pidc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_drive,
   input logic        rsp_in_deadband
);
   // transactions accepted but not yet delivered; the pipeline holds four
   logic [2:0] pending_ff, pending_in;
   logic       req_acc, rsp_acc;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (req_acc && !rsp_acc) pending_in = pending_ff + 3'd1;
      if (!req_acc && rsp_acc) pending_in = pending_ff - 3'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_drive)
                                  && $stable(rsp_in_deadband))
      else $error("stalled result changed");

   a_deadband_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_in_deadband |-> rsp_drive == 16'd0)
      else $error("deadband result with nonzero drive");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 3'd0)
      else $error("result with no transaction in flight");

   a_capacity: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 3'd4)
      else $error("more transactions in flight than pipeline stages");
endmodule

bind pid_with_deadband_and_clamps_unit pidc_checker u_pidc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_drive       (rsp_chan.drive),
   .rsp_in_deadband (rsp_chan.in_deadband)
);

// ===== dv/pid_with_deadband_and_clamps_unit_tb.sv =====
// Self-checking testbench for the PID unit: random sample traffic against an in-bench drive predictor.
module pid_with_deadband_and_clamps_unit_tb
   import pidc_pkg::*;
;

   localparam int SAMPLE_BITS = 12;
   localparam int FRAC_BITS   = 16;
   // four register stages between req and rsp
   localparam int PIPE_STAGES = 4;
   // the only index the 3-bit register field can reach beyond the map
   localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

   typedef struct packed {
      logic signed [DRIVE_W-1:0] drive;
      logic                      in_deadband;
   } drive_result_type;

   // Mirrors the unit's registers and loop state; each accepted sample
   // turns into one expected drive transaction, checked in order.
   class drive_scoreboard_type;
      logic [SETPT_W-1:0]       setpoint;
      logic [GAIN_W-1:0]        gain_p;
      logic [GAIN_W-1:0]        gain_i;
      logic [GAIN_W-1:0]        gain_d;
      logic [LIMIT_W-1:0]       integral_limit;
      logic [LIMIT_W-1:0]       output_limit;
      logic [DBAND_W-1:0]       deadband;
      logic signed [SUM_W-1:0]  error_sum;
      logic signed [12:0]       held_error;
      drive_result_type         pending_drives[$];
      int unsigned              mismatches;
      int unsigned              samples;
      int unsigned              drives_checked;
      int unsigned              band_hits;
      int unsigned              clamp_hits;

      function new();
         setpoint       = SETPOINT_RST;
         gain_p         = GAIN_P_RST;
         gain_i         = GAIN_I_RST;
         gain_d         = GAIN_D_RST;
         integral_limit = INTEGRAL_LIMIT_RST;
         output_limit   = OUTPUT_LIMIT_RST;
         deadband       = DEADBAND_RST;
         error_sum      = '0;
         held_error     = '0;
      endfunction

      // bits above each register's width drop out here
      function void write_register(logic [REG_IDX_W-1:0] idx, logic [CSR_DW-1:0] value);
         case (idx)
            REG_SETPOINT:       setpoint       = value[SETPT_W-1:0];
            REG_GAIN_P:         gain_p         = value[GAIN_W-1:0];
            REG_GAIN_I:         gain_i         = value[GAIN_W-1:0];
            REG_GAIN_D:         gain_d         = value[GAIN_W-1:0];
            REG_INTEGRAL_LIMIT: integral_limit = value[LIMIT_W-1:0];
            REG_OUTPUT_LIMIT:   output_limit   = value[LIMIT_W-1:0];
            REG_DEADBAND:       deadband       = value[DBAND_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [CSR_DW-1:0] register_value(logic [REG_IDX_W-1:0] idx);
         case (idx)
            REG_SETPOINT:       return CSR_DW'(setpoint);
            REG_GAIN_P:         return CSR_DW'(gain_p);
            REG_GAIN_I:         return CSR_DW'(gain_i);
            REG_GAIN_D:         return CSR_DW'(gain_d);
            REG_INTEGRAL_LIMIT: return CSR_DW'(integral_limit);
            REG_OUTPUT_LIMIT:   return CSR_DW'(output_limit);
            REG_DEADBAND:       return CSR_DW'(deadband);
            default:            return '0;
         endcase
      endfunction

      // One accepted sample: advance the loop state and queue its drive.
      function void note_sample(logic [SAMPLE_BITS-1:0] measured);
         int               err;
         int               mag;
         int               sum;
         int               slope;
         longint           total;
         longint           lim;
         longint           whole;
         drive_result_type res;
         samples++;
         err = int'(measured) - int'(setpoint);
         mag = (err < 0) ? -err : err;
         if (mag <= int'(deadband)) begin
            // inside the deadband: zero drive, state untouched
            res.drive       = '0;
            res.in_deadband = 1'b1;
            band_hits++;
            pending_drives.push_back(res);
            return;
         end
         sum = int'(error_sum) + err;
         if (sum > int'(integral_limit))
            sum = int'(integral_limit);
         else if (sum < -int'(integral_limit))
            sum = -int'(integral_limit);
         slope      = err - int'(held_error);
         error_sum  = SUM_W'(sum);
         held_error = 13'(err);
         // exact sum of products in units of 2^-FRAC_BITS
         total = longint'(gain_p) * err + longint'(gain_i) * sum + longint'(gain_d) * slope;
         lim   = longint'(output_limit) << FRAC_BITS;
         if (total > lim) begin
            total = lim;
            clamp_hits++;
         end else if (total < -lim) begin
            total = -lim;
            clamp_hits++;
         end
         // truncate the magnitude toward zero, then restore the sign
         whole           = ((total < 0) ? -total : total) >> FRAC_BITS;
         res.drive       = DRIVE_W'((total < 0) ? -whole : whole);
         res.in_deadband = 1'b0;
         pending_drives.push_back(res);
      endfunction

      function void check_drive(logic signed [DRIVE_W-1:0] drive, logic in_deadband);
         drive_result_type want;
         if (pending_drives.size() == 0) begin
            $error("unexpected drive transaction: drive %0d, in_deadband %0b", drive,
                   in_deadband);
            mismatches++;
            return;
         end
         want = pending_drives.pop_front();
         drives_checked++;
         if (drive !== want.drive) begin
            $error("drive mismatch: expected %0d, actual %0d", want.drive, drive);
            mismatches++;
         end
         if (in_deadband !== want.in_deadband) begin
            $error("in_deadband mismatch: expected %0b, actual %0b", want.in_deadband,
                   in_deadband);
            mismatches++;
         end
      endfunction

      function int pending();
         return pending_drives.size();
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   pidc_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_chan ();
   pidc_rsp_if                              rsp_chan ();

   drive_scoreboard_type sb = new();

   // idle percentages per phase; written by the main sequence at a rising edge
   int send_idle_pct;
   int recv_stall_pct;
   // cycles left in a forced receiver hold-off
   int hold_left;
   int unsigned reg_writes;
   int unsigned settings;

   pid_with_deadband_and_clamps_unit #(
      .SAMPLE_BITS   (SAMPLE_BITS),
      .GAIN_FRAC_BITS(FRAC_BITS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always #2 clock = ~clock;

   // Hard stop well past the slowest legal run.
   initial begin
      #1_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Receiver: ready changes on the falling edge. A pending hold-off wins
   // over the random stall so the pipe fills and backs up into req.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Every rsp transaction is compared against the oldest queued drive.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         sb.check_drive(rsp_chan.drive, rsp_chan.in_deadband);
   end

   // Offer one sample, idling first at the sender's rate; returns right after
   // the accepting edge with valid still high, so back-to-back samples keep it up.
   task automatic send_sample(input logic [SAMPLE_BITS-1:0] measured);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.measured <= measured;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_sample(measured);
   endtask

   // Drop valid, wait for every expected drive, then let the pipe settle.
   task automatic drain();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (PIPE_STAGES + 2) @(posedge clock);
   endtask

   // One APB transfer: setup cycle, access cycle, done at the pready edge.
   task automatic csr_access(input logic [REG_IDX_W-1:0] idx, input logic [CSR_DW-1:0] wdata,
                             input bit is_write, output logic [CSR_DW-1:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic read_check(input logic [REG_IDX_W-1:0] idx);
      logic [CSR_DW-1:0] got;
      csr_access(idx, '0, 1'b0, got);
      if (got !== sb.register_value(idx)) begin
         $error("register %0d readback: expected 0x%0h, actual 0x%0h", idx,
                sb.register_value(idx), got);
         sb.mismatches++;
      end
   endtask

   task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CSR_DW-1:0] value);
      logic [CSR_DW-1:0] unused;
      csr_access(idx, value, 1'b1, unused);
      sb.write_register(idx, value);
      reg_writes++;
      if (idx <= REG_DEADBAND)
         read_check(idx);
   endtask

   task automatic write_setting(input logic [CSR_DW-1:0] sp, input logic [CSR_DW-1:0] gp,
                                input logic [CSR_DW-1:0] gi, input logic [CSR_DW-1:0] gd,
                                input logic [CSR_DW-1:0] il, input logic [CSR_DW-1:0] ol,
                                input logic [CSR_DW-1:0] db);
      write_reg(REG_SETPOINT, sp);
      write_reg(REG_GAIN_P, gp);
      write_reg(REG_GAIN_I, gi);
      write_reg(REG_GAIN_D, gd);
      write_reg(REG_INTEGRAL_LIMIT, il);
      write_reg(REG_OUTPUT_LIMIT, ol);
      write_reg(REG_DEADBAND, db);
      settings++;
   endtask

   // value in the low bits, random garbage above the register's width
   function automatic logic [CSR_DW-1:0] with_junk(input int unsigned value, input int width);
      logic [CSR_DW-1:0] junk;
      junk = $urandom();
      return (junk << width) | (value & ((32'd1 << width) - 1));
   endfunction

   // Gains mostly moderate so the output clamp does not swallow everything;
   // now and then the full 24-bit range.
   function automatic int unsigned pick_gain();
      return ($urandom_range(3) == 0) ? $urandom_range(24'hFF_FFFF) : $urandom_range(1 << 18);
   endfunction

   task automatic program_random_setting();
      write_setting(with_junk($urandom_range(4095), SETPT_W),
                    with_junk(pick_gain(), GAIN_W),
                    with_junk(pick_gain(), GAIN_W),
                    with_junk(pick_gain(), GAIN_W),
                    with_junk(($urandom_range(1) ? $urandom_range(32767) : $urandom_range(300)),
                              LIMIT_W),
                    with_junk(($urandom_range(1) ? $urandom_range(32767) : $urandom_range(2000)),
                              LIMIT_W),
                    with_junk(($urandom_range(4) == 0 ? $urandom_range(4095) : $urandom_range(24)),
                              DBAND_W));
      // stray write past the map must leave everything alone
      if ($urandom_range(1))
         write_reg(REG_UNMAPPED, $urandom());
   endtask

   // Most samples sit near the setpoint so the integral, derivative and
   // deadband edges all get exercised; the rest are spread over the full range or sit at its ends.
   function automatic logic [SAMPLE_BITS-1:0] pick_sample();
      int v;
      int spread;
      case ($urandom_range(9))
         0: v = int'($urandom_range(4095));
         1: v = $urandom_range(1) ? 4095 : 0;
         default: begin
            spread = int'(sb.deadband) + 64;
            v = int'(sb.setpoint) + int'($urandom_range(2 * spread)) - spread;
         end
      endcase
      if (v < 0)
         v = 0;
      else if (v > 4095)
         v = 4095;
      return SAMPLE_BITS'(v);
   endfunction

   task automatic run_random(input int count);
      repeat (count) send_sample(pick_sample());
   endtask

   // Main sequence: reset, directed corners, then three idle profiles with
   // two random settings each; the last profile opens with a long rsp stall.
   initial begin
      reset            = 1'b1;
      req_chan.valid    = 1'b0;
      req_chan.measured = '0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      send_idle_pct    = 34;
      recv_stall_pct   = 76;
      hold_left        = 0;
      reg_writes       = 0;
      settings         = 1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // registers come out of reset at their documented values
      for (int i = REG_SETPOINT; i <= REG_DEADBAND; i++)
         read_check(REG_IDX_W'(i));

      // reset setting: zero error hits the zero-width deadband, far samples clamp
      send_sample(12'd1000);
      send_sample(12'd0);
      send_sample(12'd4095);
      send_sample(12'd1001);
      send_sample(12'd999);
      drain();

      // everything at full scale; sum keeps growing inside the wide clamp
      write_setting(32'd0, 32'hFF_FFFF, 32'hFF_FFFF, 32'hFF_FFFF, 32'd32767, 32'd32767, 32'd0);
      send_sample(12'd0);
      send_sample(12'd4095);
      send_sample(12'd4095);
      send_sample(12'd4095);
      send_sample(12'd0);
      drain();

      // all-ones write keeps only the low 12 bits: setpoint 4095, most negative error
      write_reg(REG_SETPOINT, 32'hFFFF_FFFF);
      send_sample(12'd0);
      send_sample(12'd4095);
      drain();

      // both limits zero: drive pinned at 0 but not flagged; deadband edge at +/-10
      write_setting(32'hABC0_0800, 32'hFF01_0000, 32'h0001_0000, 32'h0001_0000,
                    32'hFFFF_0000, 32'h8000_0000, 32'd10);
      send_sample(12'd2058);
      send_sample(12'd2059);
      send_sample(12'd2037);
      send_sample(12'd2038);
      drain();

      // output clamp opened, integral clamp still zero: sum stays pinned
      write_reg(REG_OUTPUT_LIMIT, 32'd32767);
      send_sample(12'd3000);
      send_sample(12'd3000);
      drain();

      // unmapped index ignored, then full-width deadband swallows every sample
      write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
      write_reg(REG_DEADBAND, 32'd4095);
      send_sample(12'd0);
      send_sample(12'd4095);
      drain();

      // sender idles lightly, receiver stalls heavily
      for (int s = 0; s < 2; s++) begin
         program_random_setting();
         run_random(250);
         drain();
      end

      // sender idles heavily, receiver stalls lightly
      send_idle_pct  = 76;
      recv_stall_pct = 34;
      for (int s = 0; s < 2; s++) begin
         program_random_setting();
         run_random(250);
         drain();
      end

      // no idling; first setting starts with a long rsp hold-off so the
      // pipe fills and req.ready drops while samples keep coming
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      for (int s = 0; s < 2; s++) begin
         program_random_setting();
         if (s == 0)
            hold_left = 64;
         run_random(250);
         drain();
      end

      $display("Covered %0d samples and %0d drive transactions: %0d in the deadband, %0d clamped.",
               sb.samples, sb.drives_checked, sb.band_hits, sb.clamp_hits);
      $display("Register traffic: %0d writes across %0d settings, three idle profiles.",
               reg_writes, settings);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/pidc_pkg.sv
rtl/pidc_req_if.sv
rtl/pidc_rsp_if.sv
rtl/pidc_csr.sv
rtl/pidc_error.sv
rtl/pidc_mult.sv
rtl/pidc_out.sv
rtl/pid_with_deadband_and_clamps_unit.sv
rtl/pidc_checker.sv
dv/pid_with_deadband_and_clamps_unit_tb.sv
